// File: hdl/emls_pkg.sv
// ----------------------------------------------------------------------------
// emls_pkg
// Shared constants and types of the extension module link supervisor.
// ----------------------------------------------------------------------------
package emls_pkg;

	localparam int MODULES_DEF  = 3;
	localparam int CHANNELS_DEF = 12;

	localparam logic [2:0] KIND_TICK  = 3'd0;
	localparam logic [2:0] KIND_RX    = 3'd1;
	localparam logic [2:0] KIND_POLL  = 3'd2;
	localparam logic [2:0] KIND_RESET = 3'd3;
	localparam logic [2:0] KIND_READ  = 3'd4;

	localparam logic [2:0] EV_STATUS  = 3'd0;
	localparam logic [2:0] EV_RAISE   = 3'd1;
	localparam logic [2:0] EV_RELEASE = 3'd2;
	localparam logic [2:0] EV_CMD     = 3'd3;
	localparam logic [2:0] EV_READ    = 3'd4;

	localparam logic [2:0] REG_MASK   = 3'd0;
	localparam logic [2:0] REG_LIMIT  = 3'd1;
	localparam logic [2:0] REG_RELAY1 = 3'd2;
	localparam logic [2:0] REG_RELAY2 = 3'd3;
	localparam logic [2:0] REG_RELAY3 = 3'd4;

	localparam logic [7:0] HDR_START = 8'h7A;
	localparam logic [7:0] HDR_TYPE  = 8'd31;
	localparam logic [7:0] HDR_CODE  = 8'h11;
	localparam logic [7:0] CMD_START = 8'h7A;
	localparam logic [7:0] CMD_LEN   = 8'd10;
	localparam logic [7:0] CMD_CODE  = 8'h21;
	localparam logic [7:0] CMD_END   = 8'hA7;
	localparam logic [2:0] RESET_POLLS = 3'd4;

	// Job handed from the front part to the back part.
	typedef struct packed {
		logic [2:0]  op;       // KIND_TICK, KIND_POLL or KIND_READ
		logic [1:0]  mod;      // poll phase or module select
		logic [7:0]  flag;     // reset flag byte for polls
		logic [31:0] relay;
		logic [15:0] cur;
		logic [2:0]  chg;      // tick: modules whose status changed
		logic [2:0]  onl;      // tick: new online flags
		logic [2:0]  en;       // tick: enable mask
	} job_t;

	typedef struct packed {
		logic [2:0]  ev;
		logic [1:0]  mod;
		logic        st;
		logic [7:0]  fb;
		logic [15:0] cur;
		logic        last;
	} res_t;

endpackage

// File: hdl/emls_front.sv
// ----------------------------------------------------------------------------
// emls_front
// Accepts words, keeps link state and current storage, and issues jobs.
// ----------------------------------------------------------------------------
module emls_front #(
	parameter int MODULES  = emls_pkg::MODULES_DEF,
	parameter int CHANNELS = emls_pkg::CHANNELS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              take,
	input  logic [2:0]        kind,
	input  logic [7:0]        data_byte,
	input  logic              frame_end,
	input  logic [1:0]        module_select,
	input  logic [3:0]        channel_select,
	input  logic [2:0]        mask,
	input  logic [7:0]        limit,
	input  logic [31:0]       relay0,
	input  logic [31:0]       relay1,
	input  logic [31:0]       relay2,
	output logic              job_valid,
	output emls_pkg::job_t    job
);
	localparam int DEPTH = MODULES * CHANNELS;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [5:0] DATA_END = 6'(4 + 2 * CHANNELS);

	logic [7:0] silence_q [3];
	logic [2:0] online_q, reported_q;
	logic [DEPTH-1:0] valid_q;
	logic [15:0] mem [DEPTH];
	logic [5:0] idx_q;
	logic hdr_ok_q;
	logic [1:0] rxmod_q;
	logic [7:0] high_q;
	logic [1:0] phase_q;
	logic rflag_q;
	logic [2:0] rcount_q;

	logic [2:0] onl_n, chg, clr;
	logic [7:0] sil_n [3];
	logic [5:0] ch6;
	logic [AW-1:0] waddr, raddr;
	logic wr, rd_ok;
	logic [2:0] rc_n;
	logic rf_n;
	logic [1:0] ph;
	logic hdr_n;

	always_comb begin
		for (int m = 0; m < 3; m++) begin
			onl_n[m] = online_q[m];
			sil_n[m] = silence_q[m];
			if (m < MODULES && 9'(silence_q[m]) + 9'd1 > 9'(limit)) begin
				onl_n[m] = 1'b0;
				sil_n[m] = limit;
			end else if (m < MODULES) begin
				sil_n[m] = silence_q[m] + 8'd1;
			end
			chg[m] = onl_n[m] != reported_q[m];
			clr[m] = chg[m] && !onl_n[m] && mask[m];
		end
		ch6 = (idx_q - 6'd4) >> 1;
		wr = take && kind == emls_pkg::KIND_RX && hdr_ok_q && idx_q >= 6'd4
			&& idx_q < DATA_END && idx_q[0] && 32'(rxmod_q) < MODULES;
		waddr = AW'(32'(rxmod_q) * CHANNELS + 32'(ch6));
		rd_ok = 32'(module_select) < MODULES && 32'(channel_select) < CHANNELS;
		raddr = AW'(32'(module_select) * CHANNELS + 32'(channel_select));
		rc_n = rflag_q ? rcount_q + 3'd1 : rcount_q;
		rf_n = rflag_q;
		if (rc_n >= emls_pkg::RESET_POLLS) begin
			rc_n = 3'd0;
			rf_n = 1'b0;
		end
		ph = (32'(phase_q) >= MODULES) ? 2'd0 : phase_q;
		hdr_n = hdr_ok_q;
		if (idx_q == 6'd0)
			hdr_n = data_byte == emls_pkg::HDR_START;
		else if (hdr_ok_q && idx_q == 6'd1)
			hdr_n = data_byte >= 8'd1 && 32'(data_byte) <= MODULES;
		else if (hdr_ok_q && idx_q == 6'd2)
			hdr_n = data_byte == emls_pkg::HDR_TYPE;
		else if (hdr_ok_q && idx_q == 6'd3)
			hdr_n = data_byte == emls_pkg::HDR_CODE;
		if (frame_end)
			hdr_n = 1'b0;
	end

	always_ff @(posedge clk) begin
		if (wr)
			mem[waddr] <= {high_q, data_byte};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int m = 0; m < 3; m++)
				silence_q[m] <= 8'd0;
			online_q <= 3'b111;
			reported_q <= 3'b111;
			valid_q <= '0;
			idx_q <= 6'd0;
			hdr_ok_q <= 1'b0;
			rxmod_q <= 2'd0;
			high_q <= 8'd0;
			phase_q <= 2'd0;
			rflag_q <= 1'b0;
			rcount_q <= 3'd0;
			job_valid <= 1'b0;
			job.op <= '0;
			job.mod <= '0;
			job.flag <= '0;
			job.relay <= '0;
			job.cur <= '0;
			job.chg <= '0;
			job.onl <= '0;
			job.en <= '0;
		end else begin
			job_valid <= take && (kind == emls_pkg::KIND_POLL || kind == emls_pkg::KIND_READ
				|| (kind == emls_pkg::KIND_TICK && |chg));
			job.cur <= (rd_ok && valid_q[raddr]) ? mem[raddr] : 16'd0;
			if (wr)
				valid_q[waddr] <= 1'b1;
			if (take) begin
				job.op <= kind;
				job.mod <= (kind == emls_pkg::KIND_POLL) ? ph : module_select;
				case (kind)
				emls_pkg::KIND_TICK: begin
					for (int m = 0; m < 3; m++)
						silence_q[m] <= sil_n[m];
					online_q <= onl_n;
					reported_q <= onl_n;
					for (int m = 0; m < MODULES; m++)
						if (clr[m])
							for (int c = 0; c < CHANNELS; c++)
								valid_q[m * CHANNELS + c] <= 1'b0;
					job.chg <= chg;
					job.onl <= onl_n;
					job.en <= mask;
				end
				emls_pkg::KIND_RX: begin
					hdr_ok_q <= hdr_n;
					if (idx_q != 6'd0 && hdr_ok_q) begin
						if (idx_q == 6'd1) begin
							if (data_byte >= 8'd1 && 32'(data_byte) <= MODULES)
								rxmod_q <= 2'(data_byte - 8'd1);
						end else if (idx_q == 6'd3) begin
							if (data_byte == emls_pkg::HDR_CODE
								&& 32'(rxmod_q) < MODULES) begin
								online_q[rxmod_q] <= 1'b1;
								silence_q[rxmod_q] <= 8'd0;
							end
						end else if (idx_q >= 6'd4 && idx_q < DATA_END && !idx_q[0]) begin
							high_q <= data_byte;
						end
					end
					if (frame_end) begin
						idx_q <= 6'd0;
					end else if (idx_q != 6'd63) begin
						idx_q <= idx_q + 6'd1;
					end
				end
				emls_pkg::KIND_POLL: begin
					rcount_q <= rc_n;
					rflag_q <= rf_n;
					phase_q <= (32'(ph) + 1 >= MODULES) ? 2'd0 : ph + 2'd1;
					job.flag <= {7'd0, rf_n};
					case (ph)
					2'd0: job.relay <= relay0;
					2'd1: job.relay <= relay1;
					default: job.relay <= relay2;
					endcase
				end
				emls_pkg::KIND_RESET: rflag_q <= 1'b1;
				default: ;
				endcase
			end
		end
	end
endmodule

// File: hdl/emls_queue.sv
// ----------------------------------------------------------------------------
// emls_queue
// Short first-in first-out queue of jobs between the front and back parts.
// ----------------------------------------------------------------------------
module emls_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           wr,
	input  emls_pkg::job_t wdata,
	input  logic           rd,
	output logic           nempty,
	output emls_pkg::job_t rdata,
	output logic [2:0]     count
);
	emls_pkg::job_t buf_q [4];
	logic [1:0] wp_q, rp_q;
	logic [2:0] cnt_q;

	assign nempty = cnt_q != 3'd0;
	assign rdata = buf_q[rp_q];
	assign count = cnt_q;

	always_ff @(posedge clk) begin
		if (wr)
			buf_q[wp_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 2'd0;
			rp_q <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			if (wr)
				wp_q <= wp_q + 2'd1;
			if (rd)
				rp_q <= rp_q + 2'd1;
			cnt_q <= cnt_q + 3'(wr) - 3'(rd);
		end
	end
endmodule

// File: hdl/emls_back.sv
// ----------------------------------------------------------------------------
// emls_back
// Expands each job into its result words and holds them in an output register.
// ----------------------------------------------------------------------------
module emls_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           job_ok,
	input  emls_pkg::job_t job,
	output logic           job_done,
	output logic           empty,
	input  logic           pop,
	output emls_pkg::res_t res
);
	logic [3:0] step_q;
	logic [2:0] done_q;      // tick: modules fully reported
	logic       fault_q;     // tick: next word is the fault word
	logic       full_q;
	emls_pkg::res_t res_q;
	emls_pkg::res_t nxt;
	logic load, fin;
	logic [1:0] tm;
	logic [2:0] left;

	assign empty = !full_q;
	assign res = res_q;
	assign load = job_ok && (!full_q || pop);

	always_comb begin
		nxt = '0;
		fin = 1'b0;
		tm = 2'd0;
		left = job.chg & ~done_q;
		if (left[0])
			tm = 2'd0;
		else if (left[1])
			tm = 2'd1;
		else
			tm = 2'd2;
		case (job.op)
		emls_pkg::KIND_POLL: begin
			nxt.ev = emls_pkg::EV_CMD;
			nxt.mod = job.mod + 2'd1;
			case (step_q)
			4'd0: nxt.fb = emls_pkg::CMD_START;
			4'd1: nxt.fb = {6'd0, job.mod + 2'd1};
			4'd2: nxt.fb = emls_pkg::CMD_LEN;
			4'd3: nxt.fb = emls_pkg::CMD_CODE;
			4'd4: nxt.fb = job.relay[7:0];
			4'd5: nxt.fb = job.relay[15:8];
			4'd6: nxt.fb = job.relay[23:16];
			4'd7: nxt.fb = job.relay[31:24];
			4'd8: nxt.fb = job.flag;
			default: nxt.fb = emls_pkg::CMD_END;
			endcase
			fin = step_q == 4'd9;
		end
		emls_pkg::KIND_READ: begin
			nxt.ev = emls_pkg::EV_READ;
			nxt.mod = job.mod + 2'd1;
			nxt.cur = job.cur;
			fin = 1'b1;
		end
		default: begin
			nxt.mod = tm + 2'd1;
			if (fault_q) begin
				nxt.ev = job.onl[tm] ? emls_pkg::EV_RELEASE : emls_pkg::EV_RAISE;
			end else begin
				nxt.ev = emls_pkg::EV_STATUS;
				nxt.st = !job.onl[tm];
			end
			fin = (fault_q || !job.en[tm]) && (left & ~(3'b1 << tm)) == 3'd0;
		end
		endcase
		nxt.last = fin;
	end

	assign job_done = load && fin;

	always_ff @(posedge clk) begin
		if (load)
			res_q <= nxt;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= 4'd0;
			done_q <= 3'd0;
			fault_q <= 1'b0;
			full_q <= 1'b0;
		end else begin
			full_q <= load || (full_q && !pop);
			if (load) begin
				if (fin) begin
					step_q <= 4'd0;
					done_q <= 3'd0;
					fault_q <= 1'b0;
				end else begin
					step_q <= step_q + 4'd1;
					if (fault_q || !job.en[tm]) begin
						done_q[tm] <= 1'b1;
						fault_q <= 1'b0;
					end else begin
						fault_q <= 1'b1;
					end
				end
			end
		end
	end
endmodule

// File: hdl/ext_module_link_supervisor.sv
// ----------------------------------------------------------------------------
// ext_module_link_supervisor
// Polls three extension modules, parses their responses and reports status.
// ----------------------------------------------------------------------------
// Channel  | Handshake         | Payload
// input    | push / full       | kind, data_byte, frame_end, module_select, ...
// result   | pop / empty       | event_res, module_number, link_status, ...
// config   | cfg_we            | cfg_index, cfg_data
//
// An item is taken when push is high and full is low; its first word passes
// the job register, a queue entry and the output register; then one word per
// cycle while pop is high: ten for a poll, up to six for a tick, one for a read.
// A four-entry job queue separates the front from the result expansion; full
// rises only when that queue is nearly full. Reset is asynchronous, active low.
module ext_module_link_supervisor #(
	parameter int MODULES  = emls_pkg::MODULES_DEF,
	parameter int CHANNELS = emls_pkg::CHANNELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [2:0]  kind,
	input  logic [7:0]  data_byte,
	input  logic        frame_end,
	input  logic [1:0]  module_select,
	input  logic [3:0]  channel_select,
	output logic        empty,
	input  logic        pop,
	output logic [2:0]  event_res,
	output logic [1:0]  module_number,
	output logic        link_status,
	output logic [7:0]  frame_byte,
	output logic [15:0] current_value,
	output logic        last,
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);
	logic [2:0] mask_q;
	logic [7:0] limit_q;
	logic [31:0] relay0_q, relay1_q, relay2_q;
	logic take, job_valid, q_ne, done;
	logic [2:0] q_cnt;
	emls_pkg::job_t job, q_job;
	emls_pkg::res_t res;

	// One job may be in flight in the front register when full is computed.
	assign full = q_cnt >= 3'd3;
	assign take = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mask_q <= 3'd7;
			limit_q <= 8'd10;
			relay0_q <= 32'd0;
			relay1_q <= 32'd0;
			relay2_q <= 32'd0;
		end else if (cfg_we) begin
			case (cfg_index)
			emls_pkg::REG_MASK:   mask_q <= cfg_data[2:0];
			emls_pkg::REG_LIMIT:  limit_q <= cfg_data[7:0];
			emls_pkg::REG_RELAY1: relay0_q <= cfg_data;
			emls_pkg::REG_RELAY2: relay1_q <= cfg_data;
			emls_pkg::REG_RELAY3: relay2_q <= cfg_data;
			default: ;
			endcase
		end
	end

	emls_front #(.MODULES(MODULES), .CHANNELS(CHANNELS)) u_front (
		.clk(clk), .arst_n(arst_n), .take(take), .kind(kind),
		.data_byte(data_byte), .frame_end(frame_end),
		.module_select(module_select), .channel_select(channel_select),
		.mask(mask_q), .limit(limit_q), .relay0(relay0_q), .relay1(relay1_q),
		.relay2(relay2_q), .job_valid(job_valid), .job(job)
	);

	emls_queue u_queue (
		.clk(clk), .arst_n(arst_n), .wr(job_valid), .wdata(job), .rd(done),
		.nempty(q_ne), .rdata(q_job), .count(q_cnt)
	);

	emls_back u_back (
		.clk(clk), .arst_n(arst_n), .job_ok(q_ne), .job(q_job), .job_done(done),
		.empty(empty), .pop(pop), .res(res)
	);

	assign event_res = res.ev;
	assign module_number = res.mod;
	assign link_status = res.st;
	assign frame_byte = res.fb;
	assign current_value = res.cur;
	assign last = res.last;
endmodule

// File: hdl/emls_checker.sv
// ----------------------------------------------------------------------------
// emls_checker
// Port-level checks of the link supervisor, bound to the top level.
// ----------------------------------------------------------------------------
module emls_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic [2:0]  event_res,
	input logic [1:0]  module_number,
	input logic [7:0]  frame_byte,
	input logic        last
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(event_res) && $stable(frame_byte))
		else $error("result word changed while stalled");
	a_mod: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && event_res != emls_pkg::EV_READ |-> module_number != 2'd0)
		else $error("module number zero");
	a_end: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && event_res == emls_pkg::EV_CMD && last
		|-> frame_byte == emls_pkg::CMD_END)
		else $error("frame end without end byte");
	a_read: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && event_res == emls_pkg::EV_READ |-> last)
		else $error("read word without last");
endmodule

bind ext_module_link_supervisor emls_checker u_emls_checker (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop),
	.event_res(event_res), .module_number(module_number),
	.frame_byte(frame_byte), .last(last)
);

// File: verif/ext_module_link_supervisor_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ext_module_link_supervisor_test
// Self-checking bench for the extension module link supervisor. Items are sent
// through the push/full side while a behavioral model of the supervisor
// predicts every result word; words popped from the result side are compared
// field by field in order. Directed tests cover polls, reset requests,
// response frames, timeouts and reads, followed by a long random mix under
// several register settings, with random idling on both sides.
// ----------------------------------------------------------------------------
module ext_module_link_supervisor_test;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        push = 1'b0;
	logic        full;
	logic [2:0]  kind = 3'd0;
	logic [7:0]  data_byte = 8'd0;
	logic        frame_end = 1'b0;
	logic [1:0]  module_select = 2'd0;
	logic [3:0]  channel_select = 4'd0;
	logic        empty;
	logic        pop = 1'b0;
	logic [2:0]  event_res;
	logic [1:0]  module_number;
	logic        link_status;
	logic [7:0]  frame_byte;
	logic [15:0] current_value;
	logic        last;
	logic        cfg_we = 1'b0;
	logic [2:0]  cfg_index = 3'd0;
	logic [31:0] cfg_data = 32'd0;

	ext_module_link_supervisor u_top (
		.clk(clk), .arst_n(arst_n), .push(push), .full(full), .kind(kind),
		.data_byte(data_byte), .frame_end(frame_end), .module_select(module_select),
		.channel_select(channel_select), .empty(empty), .pop(pop),
		.event_res(event_res), .module_number(module_number),
		.link_status(link_status), .frame_byte(frame_byte),
		.current_value(current_value), .last(last), .cfg_we(cfg_we),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Supervisor model state.
	logic [2:0]  en_mask;
	logic [7:0]  off_limit;
	logic [31:0] relay [3];
	logic [7:0]  silence [3];
	logic        online [3];
	logic        reported [3];
	logic [15:0] cur_store [3][12];
	logic [5:0]  rx_idx;
	logic        rx_ok;
	logic [1:0]  rx_mod;
	logic [7:0]  rx_hi;
	logic [1:0]  phase;
	logic        rst_flag;
	logic [2:0]  rst_polls;

	emls_pkg::res_t exp_words[$];
	int   errors = 0;
	bit   quiet = 0;
	int   pop_stall = 0;

	task automatic model_reset();
		en_mask = 3'd7;
		off_limit = 8'd10;
		for (int m = 0; m < 3; m++) begin
			relay[m] = 32'd0;
			silence[m] = 8'd0;
			online[m] = 1'b1;
			reported[m] = 1'b1;
			for (int c = 0; c < 12; c++) cur_store[m][c] = 16'd0;
		end
		rx_idx = 6'd0;
		rx_ok = 1'b0;
		rx_mod = 2'd0;
		rx_hi = 8'd0;
		phase = 2'd0;
		rst_flag = 1'b0;
		rst_polls = 3'd0;
	endtask

	function automatic void add_word(logic [2:0] ev, logic [1:0] md, logic st,
		logic [7:0] fb, logic [15:0] cv);
		emls_pkg::res_t w;
		w.ev = ev;
		w.mod = md;
		w.st = st;
		w.fb = fb;
		w.cur = cv;
		w.last = 1'b0;
		exp_words.push_back(w);
	endfunction

	task automatic predict_item(logic [2:0] k, logic [7:0] b, logic e, logic [1:0] ms,
		logic [3:0] cs);
		int n0;
		int nxt;
		logic [7:0] fr [10];
		n0 = exp_words.size();
		case (k)
			emls_pkg::KIND_TICK: begin
				for (int m = 0; m < 3; m++) begin
					nxt = int'(silence[m]) + 1;
					if (nxt > int'(off_limit)) begin
						nxt = off_limit;
						online[m] = 1'b0;
					end
					silence[m] = nxt[7:0];
				end
				for (int m = 0; m < 3; m++) begin
					if (online[m] != reported[m]) begin
						add_word(emls_pkg::EV_STATUS, 2'(m + 1), !online[m], 8'd0, 16'd0);
						if (en_mask[m]) begin
							if (!online[m]) begin
								add_word(emls_pkg::EV_RAISE, 2'(m + 1), 1'b0, 8'd0, 16'd0);
								for (int c = 0; c < 12; c++) cur_store[m][c] = 16'd0;
							end else begin
								add_word(emls_pkg::EV_RELEASE, 2'(m + 1), 1'b0, 8'd0,
									16'd0);
							end
						end
						reported[m] = online[m];
					end
				end
			end
			emls_pkg::KIND_RX: begin
				if (rx_idx == 0) begin
					rx_ok = (b == emls_pkg::HDR_START);
				end else if (rx_ok) begin
					if (rx_idx == 1) begin
						if (b >= 1 && b <= 3) rx_mod = 2'(b - 1);
						else rx_ok = 1'b0;
					end else if (rx_idx == 2) begin
						if (b != emls_pkg::HDR_TYPE) rx_ok = 1'b0;
					end else if (rx_idx == 3) begin
						if (b != emls_pkg::HDR_CODE) begin
							rx_ok = 1'b0;
						end else if (rx_mod < 3) begin
							online[rx_mod] = 1'b1;
							silence[rx_mod] = 8'd0;
						end
					end else if (rx_idx < 28) begin
						if (!rx_idx[0]) rx_hi = b;
						else if (rx_mod < 3) cur_store[rx_mod][(rx_idx - 4) >> 1] = {rx_hi, b};
					end
				end
				if (e) begin
					rx_idx = 6'd0;
					rx_ok = 1'b0;
				end else if (rx_idx < 63) begin
					rx_idx = rx_idx + 6'd1;
				end
			end
			emls_pkg::KIND_POLL: begin
				if (rst_flag) rst_polls = rst_polls + 3'd1;
				if (rst_polls >= emls_pkg::RESET_POLLS) begin
					rst_polls = 3'd0;
					rst_flag = 1'b0;
				end
				if (phase >= 3) phase = 2'd0;
				fr[0] = emls_pkg::CMD_START;
				fr[1] = 8'(phase + 1);
				fr[2] = emls_pkg::CMD_LEN;
				fr[3] = emls_pkg::CMD_CODE;
				fr[4] = relay[phase][7:0];
				fr[5] = relay[phase][15:8];
				fr[6] = relay[phase][23:16];
				fr[7] = relay[phase][31:24];
				fr[8] = {7'd0, rst_flag};
				fr[9] = emls_pkg::CMD_END;
				for (int i = 0; i < 10; i++)
					add_word(emls_pkg::EV_CMD, 2'(phase + 1), 1'b0, fr[i], 16'd0);
				phase = (phase == 2) ? 2'd0 : phase + 2'd1;
			end
			emls_pkg::KIND_RESET: rst_flag = 1'b1;
			emls_pkg::KIND_READ: begin
				add_word(emls_pkg::EV_READ, ms + 2'd1, 1'b0, 8'd0,
					(ms < 3 && cs < 12) ? cur_store[ms][cs] : 16'd0);
			end
			default: ;
		endcase
		if (exp_words.size() > n0) exp_words[exp_words.size() - 1].last = 1'b1;
	endtask

	task automatic send_item(logic [2:0] k, logic [7:0] b = 8'd0, logic e = 1'b0,
		logic [1:0] ms = 2'd0, logic [3:0] cs = 4'd0);
		int gap;
		if (!quiet && $urandom_range(0, 5) == 0) begin
			gap = $urandom_range(1, 14);
			repeat (gap) begin
				@(negedge clk);
				push <= 1'b0;
			end
		end
		@(negedge clk);
		push <= 1'b1;
		kind <= k;
		data_byte <= b;
		frame_end <= e;
		module_select <= ms;
		channel_select <= cs;
		forever begin
			@(posedge clk);
			if (!full) break;
		end
		predict_item(k, b, e, ms, cs);
	endtask

	// Stops sending and waits until the block has delivered everything.
	task automatic drain();
		@(negedge clk);
		push <= 1'b0;
		while (exp_words.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			emls_pkg::REG_MASK:   en_mask = val[2:0];
			emls_pkg::REG_LIMIT:  off_limit = val[7:0];
			emls_pkg::REG_RELAY1: relay[0] = val;
			emls_pkg::REG_RELAY2: relay[1] = val;
			emls_pkg::REG_RELAY3: relay[2] = val;
			default: ;
		endcase
	endtask

	// Sends one response frame; corrupt_at >= 0 replaces that byte at random.
	task automatic send_frame(int addr, int len, int corrupt_at);
		logic [7:0] b;
		for (int i = 0; i < len; i++) begin
			case (i)
				0: b = emls_pkg::HDR_START;
				1: b = 8'(addr);
				2: b = emls_pkg::HDR_TYPE;
				3: b = emls_pkg::HDR_CODE;
				default: b = 8'($urandom_range(0, 255));
			endcase
			if (i == corrupt_at) b = 8'($urandom_range(0, 255));
			send_item(emls_pkg::KIND_RX, b, i == len - 1);
		end
	endtask

	task automatic random_item();
		int r;
		r = $urandom_range(0, 99);
		if (r < 30) begin
			send_frame($urandom_range(0, 9) == 0 ? $urandom_range(0, 255) : $urandom_range(1, 3),
				$urandom_range(0, 7) == 0 ? $urandom_range(1, 40) : 28,
				$urandom_range(0, 5) == 0 ? $urandom_range(0, 3) : -1);
		end else if (r < 45) begin
			send_item(emls_pkg::KIND_TICK);
		end else if (r < 60) begin
			send_item(emls_pkg::KIND_POLL);
		end else if (r < 66) begin
			send_item(emls_pkg::KIND_RESET);
		end else if (r < 86) begin
			send_item(emls_pkg::KIND_READ, 8'($urandom), 1'($urandom), 2'($urandom),
				4'($urandom));
		end else if (r < 94) begin
			send_item(emls_pkg::KIND_RX, 8'($urandom), 1'($urandom));
		end else begin
			send_item(3'($urandom_range(5, 7)), 8'($urandom), 1'($urandom), 2'($urandom),
				4'($urandom));
		end
	endtask

	task automatic test_directed();
		send_item(emls_pkg::KIND_READ, 8'd0, 1'b0, 2'd0, 4'd0);
		send_item(emls_pkg::KIND_READ, 8'hFF, 1'b1, 2'd3, 4'd15);
		send_item(emls_pkg::KIND_READ, 8'd0, 1'b0, 2'd2, 4'd12);
		send_item(emls_pkg::KIND_POLL);
		send_item(emls_pkg::KIND_RESET);
		repeat (5) send_item(emls_pkg::KIND_POLL);
		send_frame(2, 28, -1);
		send_item(emls_pkg::KIND_READ, 8'd0, 1'b0, 2'd1, 4'd11);
		send_item(emls_pkg::KIND_TICK);
		send_item(3'd5);
		send_item(3'd6);
		send_item(3'd7, 8'hFF, 1'b1, 2'd3, 4'd15);
		drain();
	endtask

	task automatic test_timeout();
		write_reg(emls_pkg::REG_LIMIT, 32'd1);
		write_reg(emls_pkg::REG_MASK, 32'd5);
		write_reg(emls_pkg::REG_RELAY1, 32'hFFFF_FFFF);
		write_reg(emls_pkg::REG_RELAY2, 32'h1234_5678);
		write_reg(emls_pkg::REG_RELAY3, 32'hA5C3_0F96);
		repeat (3) send_item(emls_pkg::KIND_TICK);
		send_frame(1, 28, -1);
		send_frame(2, 10, -1);
		send_item(emls_pkg::KIND_TICK);
		send_item(emls_pkg::KIND_READ, 8'd0, 1'b0, 2'd0, 4'd3);
		repeat (3) send_item(emls_pkg::KIND_POLL);
		drain();
		write_reg(emls_pkg::REG_LIMIT, 32'd255);
		write_reg(emls_pkg::REG_MASK, 32'd0);
		send_frame(3, 28, -1);
		repeat (4) send_item(emls_pkg::KIND_TICK);
		drain();
	endtask

	task automatic test_random();
		for (int ph = 0; ph < 6; ph++) begin
			write_reg(emls_pkg::REG_MASK, 32'($urandom_range(0, 7)));
			write_reg(emls_pkg::REG_LIMIT, (ph == 1) ? 32'd1 : (ph == 2) ? 32'd255 :
				32'($urandom_range(1, 12)));
			write_reg(emls_pkg::REG_RELAY1, (ph == 3) ? 32'd0 : $urandom);
			write_reg(emls_pkg::REG_RELAY2, (ph == 3) ? 32'hFFFF_FFFF : $urandom);
			write_reg(emls_pkg::REG_RELAY3, $urandom);
			if (ph == 5) quiet = 1;
			repeat (6) random_item();
			drain();
		end
	endtask

	always @(negedge clk) begin
		if (pop_stall > 0) begin
			pop_stall <= pop_stall - 1;
			pop <= 1'b0;
		end else if (!quiet && arst_n && $urandom_range(0, 9) == 0) begin
			pop_stall <= $urandom_range(1, 14) - 1;
			pop <= 1'b0;
		end else begin
			pop <= 1'b1;
		end
	end

	always @(posedge clk) begin
		emls_pkg::res_t w;
		if (arst_n && pop && !empty) begin
			if (exp_words.size() == 0) begin
				$error("unexpected word: event_res %0d module_number %0d", event_res,
					module_number);
				errors++;
			end else begin
				w = exp_words.pop_front();
				if (event_res !== w.ev) begin
					$error("event_res: expected %0d, got %0d", w.ev, event_res);
					errors++;
				end
				if (module_number !== w.mod) begin
					$error("module_number: expected %0d, got %0d", w.mod, module_number);
					errors++;
				end
				if (link_status !== w.st) begin
					$error("link_status: expected %0d, got %0d", w.st, link_status);
					errors++;
				end
				if (frame_byte !== w.fb) begin
					$error("frame_byte: expected %0h, got %0h", w.fb, frame_byte);
					errors++;
				end
				if (current_value !== w.cur) begin
					$error("current_value: expected %0h, got %0h", w.cur, current_value);
					errors++;
				end
				if (last !== w.last) begin
					$error("last: expected %0d, got %0d", w.last, last);
					errors++;
				end
			end
		end
	end

	initial begin
		model_reset();
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_timeout();
		test_random();
		drain();
		if (errors == 0 && exp_words.size() == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("TEST FAILED");
		$finish;
	end

endmodule

// File: sim.f
hdl/emls_pkg.sv
hdl/emls_front.sv
hdl/emls_queue.sv
hdl/emls_back.sv
hdl/ext_module_link_supervisor.sv
hdl/emls_checker.sv
verif/ext_module_link_supervisor_test.sv
